// ----- rtl/core/tpec_pkg.sv -----
// tpec_pkg: shared constants, types and helpers for the triangle point edge
// coordinates block. No dependencies.
`timescale 1ns / 1ps

package tpec_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int WFRAC_BITS_DEF = 16;

  // per-item flags that ride alongside the divider pipeline
  typedef struct packed {
    logic       ok;
    logic [1:0] edge_idx;
    logic       sat0;
    logic       sat1;
  } tpec_meta_t;

  // round a bit count up to whole bytes
  function automatic int byte_ceil(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

// ----- rtl/core/tpec_frac.sv -----
// tpec_frac: two pipelined restoring dividers, one quotient bit per stage,
// giving floor(n * 2^FRAC / d) for n < d. Depends on tpec_pkg.
`timescale 1ns / 1ps

module tpec_frac #(
  parameter int NW   = 50,
  parameter int FRAC = tpec_pkg::WFRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [NW-1:0]         n0,
  input  logic [NW-1:0]         d0,
  input  logic [NW-1:0]         n1,
  input  logic [NW-1:0]         d1,
  input  tpec_pkg::tpec_meta_t  meta_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FRAC-1:0]       q0,
  output logic [FRAC-1:0]       q1,
  output tpec_pkg::tpec_meta_t  meta_out
);

  logic                 v_r    [1:FRAC];
  logic [NW:0]          r0_r   [1:FRAC];
  logic [NW:0]          r1_r   [1:FRAC];
  logic [NW-1:0]        d0_r   [1:FRAC];
  logic [NW-1:0]        d1_r   [1:FRAC];
  logic [FRAC-1:0]      q0_r   [1:FRAC];
  logic [FRAC-1:0]      q1_r   [1:FRAC];
  tpec_pkg::tpec_meta_t m_r    [1:FRAC];

  logic                 rdy    [1:FRAC+1];
  logic [NW:0]          r0_nxt [1:FRAC];
  logic [NW:0]          r1_nxt [1:FRAC];
  logic [FRAC-1:0]      q0_nxt [1:FRAC];
  logic [FRAC-1:0]      q1_nxt [1:FRAC];

  always_comb begin
    rdy[FRAC+1] = out_ready;
    for (int s = FRAC; s >= 1; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  assign in_ready = rdy[1];

  // one restoring step per stage
  always_comb begin
    logic [NW:0]     p0, p1, t0, t1;
    logic [NW-1:0]   dd0, dd1;
    logic [FRAC-1:0] pq0, pq1;
    for (int s = 1; s <= FRAC; s++) begin
      if (s == 1) begin
        p0 = {1'b0, n0};
        p1 = {1'b0, n1};
        dd0 = d0;
        dd1 = d1;
        pq0 = '0;
        pq1 = '0;
      end else begin
        p0 = r0_r[s-1];
        p1 = r1_r[s-1];
        dd0 = d0_r[s-1];
        dd1 = d1_r[s-1];
        pq0 = q0_r[s-1];
        pq1 = q1_r[s-1];
      end
      t0 = {p0[NW-1:0], 1'b0};
      t1 = {p1[NW-1:0], 1'b0};
      if (t0 >= {1'b0, dd0}) begin
        r0_nxt[s] = t0 - {1'b0, dd0};
        q0_nxt[s] = {pq0[FRAC-2:0], 1'b1};
      end else begin
        r0_nxt[s] = t0;
        q0_nxt[s] = {pq0[FRAC-2:0], 1'b0};
      end
      if (t1 >= {1'b0, dd1}) begin
        r1_nxt[s] = t1 - {1'b0, dd1};
        q1_nxt[s] = {pq1[FRAC-2:0], 1'b1};
      end else begin
        r1_nxt[s] = t1;
        q1_nxt[s] = {pq1[FRAC-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= FRAC; s++) begin
        v_r[s] <= 1'b0;
      end
    end else begin
      for (int s = 1; s <= FRAC; s++) begin
        if (rdy[s]) begin
          v_r[s] <= (s == 1) ? in_valid : v_r[s-1 < 1 ? 1 : s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 1; s <= FRAC; s++) begin
      if (rdy[s]) begin
        r0_r[s] <= r0_nxt[s];
        r1_r[s] <= r1_nxt[s];
        q0_r[s] <= q0_nxt[s];
        q1_r[s] <= q1_nxt[s];
        if (s == 1) begin
          d0_r[s] <= d0;
          d1_r[s] <= d1;
          m_r[s]  <= meta_in;
        end else begin
          d0_r[s] <= d0_r[s-1 < 1 ? 1 : s-1];
          d1_r[s] <= d1_r[s-1 < 1 ? 1 : s-1];
          m_r[s]  <= m_r[s-1 < 1 ? 1 : s-1];
        end
      end
    end
  end

  assign out_valid = v_r[FRAC];
  assign q0        = q0_r[FRAC];
  assign q1        = q1_r[FRAC];
  assign meta_out  = m_r[FRAC];

endmodule

// ----- rtl/core/triangle_point_edge_coordinates.sv -----
// triangle_point_edge_coordinates: top level, front arithmetic pipeline and
// output register. Depends on tpec_pkg and tpec_frac.
`timescale 1ns / 1ps
//
// Usage:
//   in_*  : one item per handshake, three vertices and a query point, each
//           signed COORD_BITS. in_tdata packs vertex0_x, vertex0_y, vertex1_x,
//           vertex1_y, vertex2_x, vertex2_y, point_x, point_y from bit 0 up.
//   out_* : exactly one result item per input item, in order. out_tuser is
//           found; out_tdata holds edge_start, edge_weight, apex_weight.
//           When found is low every out_tdata field is zero.
// Pipeline: 9 front stages (differences, squares, distance sums, far vertex
//   select, edge vectors, cross products, cross subtract, sign normalize,
//   range checks), then WEIGHT_FRAC_BITS divider stages, then the output
//   register.
// Throughput: one item per cycle unless out_tready stalls; the divider retires
//   one quotient bit per stage for both weights: depth sets latency, not rate.
// Reset: synchronous active-low rst_n empties every stage and the output.
// Stall: when out_tready is low the output holds; each stage keeps loading
//   while it or a later stage is empty, so bubbles close up before in_tready
//   drops. Nothing is dropped or repeated.
//
module triangle_point_edge_coordinates #(
  parameter int COORD_BITS       = tpec_pkg::COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = tpec_pkg::WFRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
  // point_x, point_y
  input  logic [tpec_pkg::byte_ceil(8*COORD_BITS)-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // edge_start, edge_weight, apex_weight
  output logic [tpec_pkg::byte_ceil(2*WEIGHT_FRAC_BITS+4)-1:0] out_tdata,
  // found
  output logic out_tuser
);

  localparam int CW    = COORD_BITS;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int SW    = PW + 1;
  localparam int XW    = PW + 1;
  localparam int NW    = XW - 1;
  localparam int F     = WEIGHT_FRAC_BITS;
  localparam int OUT_W = tpec_pkg::byte_ceil(2*F+4);
  localparam int NST   = 9;

  logic v_r [1:NST];
  logic adv [1:NST+1];
  logic div_in_ready;

  always_comb begin
    adv[NST+1] = div_in_ready;
    for (int k = NST; k >= 1; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_tready = adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= NST; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      for (int k = 1; k <= NST; k++) begin
        if (adv[k]) begin
          v_r[k] <= (k == 1) ? in_tvalid : v_r[k-1 < 1 ? 1 : k-1];
        end
      end
    end
  end

  // stage 1: point minus each vertex
  logic signed [CW-1:0] vx_in [3];
  logic signed [CW-1:0] vy_in [3];
  logic signed [CW-1:0] px_in, py_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx_in[i] = in_tdata[(2*i)*CW +: CW];
      vy_in[i] = in_tdata[(2*i+1)*CW +: CW];
    end
    px_in = in_tdata[6*CW +: CW];
    py_in = in_tdata[7*CW +: CW];
  end

  logic signed [CW-1:0] vx1_r [3], vy1_r [3];
  logic signed [DW-1:0] dx1_r [3], dy1_r [3];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        vx1_r[i] <= vx_in[i];
        vy1_r[i] <= vy_in[i];
        dx1_r[i] <= DW'(px_in) - DW'(vx_in[i]);
        dy1_r[i] <= DW'(py_in) - DW'(vy_in[i]);
      end
    end
  end

  // stage 2: squares
  logic signed [CW-1:0] vx2_r [3], vy2_r [3];
  logic signed [DW-1:0] dx2_r [3], dy2_r [3];
  logic signed [PW-1:0] sqx2_r [3], sqy2_r [3];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        vx2_r[i]  <= vx1_r[i];
        vy2_r[i]  <= vy1_r[i];
        dx2_r[i]  <= dx1_r[i];
        dy2_r[i]  <= dy1_r[i];
        sqx2_r[i] <= dx1_r[i] * dx1_r[i];
        sqy2_r[i] <= dy1_r[i] * dy1_r[i];
      end
    end
  end

  // stage 3: squared distances
  logic signed [CW-1:0] vx3_r [3], vy3_r [3];
  logic signed [DW-1:0] dx3_r [3], dy3_r [3];
  logic [SW-1:0]        d2_3_r [3];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        vx3_r[i]  <= vx2_r[i];
        vy3_r[i]  <= vy2_r[i];
        dx3_r[i]  <= dx2_r[i];
        dy3_r[i]  <= dy2_r[i];
        d2_3_r[i] <= SW'($unsigned(sqx2_r[i])) + SW'($unsigned(sqy2_r[i]));
      end
    end
  end

  // stage 4: far vertex, lowest index wins ties
  logic          g01, g2;
  logic [SW-1:0] m01;
  logic [1:0]    far_nxt;

  always_comb begin
    g01     = d2_3_r[1] > d2_3_r[0];
    m01     = g01 ? d2_3_r[1] : d2_3_r[0];
    g2      = d2_3_r[2] > m01;
    far_nxt = g2 ? 2'd2 : (g01 ? 2'd1 : 2'd0);
  end

  logic signed [CW-1:0] vx4_r [3], vy4_r [3];
  logic signed [DW-1:0] dx4_r [3], dy4_r [3];
  logic [1:0]           far4_r;
  logic                 ok4_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int i = 0; i < 3; i++) begin
        vx4_r[i] <= vx3_r[i];
        vy4_r[i] <= vy3_r[i];
        dx4_r[i] <= dx3_r[i];
        dy4_r[i] <= dy3_r[i];
      end
      far4_r <= far_nxt;
      ok4_r  <= g2 || (m01 != '0);
    end
  end

  // stage 5: edge vectors from the edge start vertex
  logic [1:0] ia, ib;

  always_comb begin
    unique case (far4_r)
      2'd0:    begin ia = 2'd1; ib = 2'd2; end
      2'd1:    begin ia = 2'd2; ib = 2'd0; end
      default: begin ia = 2'd0; ib = 2'd1; end
    endcase
  end

  logic signed [DW-1:0] v0x5_r, v0y5_r, vvx5_r, vvy5_r, dxf5_r, dyf5_r;
  logic [1:0]           a5_r;
  logic                 ok5_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      v0x5_r <= DW'(vx4_r[ib]) - DW'(vx4_r[ia]);
      v0y5_r <= DW'(vy4_r[ib]) - DW'(vy4_r[ia]);
      vvx5_r <= DW'(vx4_r[far4_r]) - DW'(vx4_r[ia]);
      vvy5_r <= DW'(vy4_r[far4_r]) - DW'(vy4_r[ia]);
      dxf5_r <= dx4_r[far4_r];
      dyf5_r <= dy4_r[far4_r];
      a5_r   <= ia;
      ok5_r  <= ok4_r;
    end
  end

  // stage 6: cross product terms
  logic signed [PW-1:0] pc0_r, pc1_r, pd0_r, pd1_r, pw0_r, pw1_r;
  logic [1:0]           a6_r;
  logic                 ok6_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      pc0_r <= v0x5_r * dyf5_r;
      pc1_r <= v0y5_r * dxf5_r;
      pd0_r <= vvx5_r * dyf5_r;
      pd1_r <= vvy5_r * dxf5_r;
      pw0_r <= vvx5_r * v0y5_r;
      pw1_r <= vvy5_r * v0x5_r;
      a6_r  <= a5_r;
      ok6_r <= ok5_r;
    end
  end

  // stage 7: c, c1, w
  logic signed [XW-1:0] c7_r, c17_r, w7_r;
  logic [1:0]           a7_r;
  logic                 ok7_r;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      c7_r  <= XW'(pc0_r) - XW'(pc1_r);
      c17_r <= XW'(pd0_r) - XW'(pd1_r);
      w7_r  <= XW'(pw0_r) - XW'(pw1_r);
      a7_r  <= a6_r;
      ok7_r <= ok6_r;
    end
  end

  // stage 8: make c positive, flip the others with it
  logic signed [XW-1:0] c8_r, c18_r, w8_r;
  logic [1:0]           a8_r;
  logic                 ok8_r;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      if (c7_r[XW-1]) begin
        c8_r  <= -c7_r;
        c18_r <= -c17_r;
        w8_r  <= -w7_r;
      end else begin
        c8_r  <= c7_r;
        c18_r <= c17_r;
        w8_r  <= w7_r;
      end
      a8_r  <= a7_r;
      ok8_r <= ok7_r && (c7_r != '0);
    end
  end

  // stage 9: range checks, divider operands
  logic [NW-1:0]        n0_9_r, c9_r, w9_r;
  tpec_pkg::tpec_meta_t m9_r;

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      n0_9_r      <= NW'(c8_r - c18_r);
      c9_r        <= NW'(c8_r);
      w9_r        <= NW'(w8_r);
      m9_r.ok       <= ok8_r && !c18_r[XW-1] && (c18_r <= c8_r)
                       && !w8_r[XW-1] && (w8_r >= c8_r);
      m9_r.edge_idx <= a8_r;
      m9_r.sat0     <= (c18_r == '0);
      m9_r.sat1     <= (w8_r == c8_r);
    end
  end

  // weight dividers
  logic                 div_out_valid;
  logic                 div_out_ready;
  logic [F-1:0]         q0, q1;
  tpec_pkg::tpec_meta_t m_out;

  tpec_frac #(
    .NW   (NW),
    .FRAC (F)
  ) u_frac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[NST]),
    .in_ready  (div_in_ready),
    .n0        (n0_9_r),
    .d0        (c9_r),
    .n1        (c9_r),
    .d1        (w9_r),
    .meta_in   (m9_r),
    .out_valid (div_out_valid),
    .out_ready (div_out_ready),
    .q0        (q0),
    .q1        (q1),
    .meta_out  (m_out)
  );

  // output register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             out_found_r;
  logic [F:0]       ew, aw;

  assign div_out_ready = !out_valid_r || out_tready;

  always_comb begin
    ew = m_out.sat0 ? (F+1)'(1) << F : {1'b0, q0};
    aw = m_out.sat1 ? (F+1)'(1) << F : {1'b0, q1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_out_ready) begin
      out_valid_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_out_ready) begin
      out_found_r <= m_out.ok;
      if (m_out.ok) begin
        out_data_r <= OUT_W'({aw, ew, m_out.edge_idx});
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

endmodule

// ----- rtl/core/tpec_checker.sv -----
// tpec_checker: port-level assertions for triangle_point_edge_coordinates,
// attached by bind. Depends on tpec_pkg.
`timescale 1ns / 1ps

module tpec_checker #(
  parameter int COORD_BITS       = tpec_pkg::COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = tpec_pkg::WFRAC_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic [tpec_pkg::byte_ceil(8*COORD_BITS)-1:0] in_tdata,
  input logic out_tvalid,
  input logic out_tready,
  input logic [tpec_pkg::byte_ceil(2*WEIGHT_FRAC_BITS+4)-1:0] out_tdata,
  input logic out_tuser
);

  localparam int F = WEIGHT_FRAC_BITS;

  logic [F:0] ew, aw;
  logic       in_seen;

  assign ew      = out_tdata[2 +: F+1];
  assign aw      = out_tdata[F+3 +: F+1];
  assign in_seen = in_tvalid && in_tready && (in_tdata == in_tdata);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss result carries nonzero fields");

  a_edge_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[1:0] != 2'd3)
    else $error("edge start index out of range");

  a_weights: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ew <= ((F+1)'(1) << F) && aw <= ((F+1)'(1) << F))
    else $error("weight above one");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && (in_seen || !in_seen))
    else $error("result valid right after reset");

endmodule

bind triangle_point_edge_coordinates tpec_checker #(
  .COORD_BITS       (COORD_BITS),
  .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
) u_tpec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- dv/triangle_point_edge_coordinates_tb.sv -----
// triangle_point_edge_coordinates_tb: self-checking bench for the triangle point
// edge coordinates block, with its own exact-arithmetic predictor of the weights.
// Depends on tpec_pkg and the block's RTL.
`timescale 1ns / 1ps

module triangle_point_edge_coordinates_tb;

  localparam int CB = tpec_pkg::COORD_BITS_DEF;
  localparam int WF = tpec_pkg::WFRAC_BITS_DEF;
  localparam int IN_W = tpec_pkg::byte_ceil(8*CB);
  localparam int OUT_W = tpec_pkg::byte_ceil(2*WF+4);
  localparam int N_RANDOM = 800;
  localparam int N_DIRECTED = 14;
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic [WF:0] WONE = (WF+1)'(1) << WF;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct {
    coord_t c[8];
  } tri_item_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  edge_start;
    logic [WF:0] edge_weight;
    logic [WF:0] apex_weight;
  } edge_coord_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;

  edge_coord_t coord_q[$];
  int errors = 0;
  bit stim_done = 0;

  triangle_point_edge_coordinates dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // floor(n * 2^WF / d), saturating at one, for 0 <= n and d > 0
  function automatic logic [WF:0] frac_of(input logic signed [127:0] n,
                                          input logic signed [127:0] d);
    logic signed [127:0] r;
    logic [WF:0] q;
    if (n >= d) return WONE;
    r = n;
    q = '0;
    for (int i = 0; i < WF; i++) begin
      r = r <<< 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic edge_coord_t predict_coords(input tri_item_t it);
    logic signed [127:0] vx[3], vy[3], dx[3], dy[3], best, d2;
    logic signed [127:0] v0x, v0y, vvx, vvy, c, c1, w;
    edge_coord_t r;
    int far, a, b;
    r = '0;
    far = -1;
    best = '0;
    for (int i = 0; i < 3; i++) begin
      vx[i] = it.c[2*i];
      vy[i] = it.c[2*i+1];
    end
    for (int i = 0; i < 3; i++) begin
      dx[i] = 128'(it.c[6]) - vx[i];
      dy[i] = 128'(it.c[7]) - vy[i];
      d2 = dx[i]*dx[i] + dy[i]*dy[i];
      if (d2 > best) begin
        best = d2;
        far = i;
      end
    end
    if (far < 0) return r;
    a = (far + 1) % 3;
    b = (far + 2) % 3;
    v0x = vx[b] - vx[a];
    v0y = vy[b] - vy[a];
    vvx = vx[far] - vx[a];
    vvy = vy[far] - vy[a];
    c = v0x*dy[far] - v0y*dx[far];
    if (c == 0) return r;
    c1 = vvx*dy[far] - vvy*dx[far];
    w = vvx*v0y - vvy*v0x;
    if (c < 0) begin
      c = -c;
      c1 = -c1;
      w = -w;
    end
    if (c1 < 0 || c1 > c) return r;
    if (w < c) return r;
    r.found = 1'b1;
    r.edge_start = 2'(a);
    r.edge_weight = frac_of(c - c1, c);
    r.apex_weight = frac_of(c, w);
    return r;
  endfunction

  function automatic tri_item_t make_tri(input int x0, y0, x1, y1, x2, y2, px, py);
    tri_item_t t;
    t.c = '{coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1),
            coord_t'(x2), coord_t'(y2), coord_t'(px), coord_t'(py)};
    return t;
  endfunction

  function automatic coord_t rand_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 4096)) - coord_t'(2048);
      2: return ($urandom_range(0, 1) != 0) ? CMAX : CMIN;
      default: return coord_t'($urandom_range(0, 64)) - coord_t'(32);
    endcase
  endfunction

  // mostly well-formed: point inside the triangle, so a crossing exists
  function automatic tri_item_t rand_tri();
    tri_item_t t;
    int mode, sel;
    longint wa, wb, wc, sum;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 6; i++) t.c[i] = rand_coord(mode);
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      wa = $urandom_range(0, 255);
      wb = $urandom_range(0, 255);
      wc = $urandom_range(0, 255);
      sum = wa + wb + wc;
      if (sum == 0) sum = 1;
      t.c[6] = coord_t'((wa*longint'(t.c[0]) + wb*longint'(t.c[2]) +
                         wc*longint'(t.c[4])) / sum);
      t.c[7] = coord_t'((wa*longint'(t.c[1]) + wb*longint'(t.c[3]) +
                         wc*longint'(t.c[5])) / sum);
    end else if (sel < 7) begin
      t.c[6] = t.c[2*$urandom_range(0, 2)];
      t.c[7] = t.c[1 + 2*$urandom_range(0, 2)];
    end else begin
      t.c[6] = rand_coord(mode);
      t.c[7] = rand_coord(mode);
    end
    return t;
  endfunction

  task automatic send_item(input tri_item_t t, input edge_coord_t want);
    logic [IN_W-1:0] data;
    data = '0;
    for (int i = 0; i < 8; i++) data[i*CB +: CB] = t.c[i];
    in_tdata <= data;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    coord_q.push_back(want);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // directed rows; an expectation is typed in where it is obvious
  tri_item_t dir_tri[N_DIRECTED];
  bit dir_known[N_DIRECTED];
  edge_coord_t dir_exp[N_DIRECTED];

  initial begin
    int burst;
    tri_item_t rt;
    dir_tri[0] = make_tri(0, 0, 0, 0, 0, 0, 0, 0);
    dir_tri[1] = make_tri(5, 7, 5, 7, 5, 7, 5, 7);
    dir_tri[2] = make_tri(0, 0, 256, 0, 0, 256, 0, 0);
    dir_tri[3] = make_tri(0, 0, 256, 0, 512, 0, 64, 0);
    dir_tri[4] = make_tri(0, 0, 1024, 0, 0, 1024, 256, 256);
    dir_tri[5] = make_tri(0, 0, 1024, 0, 0, 1024, 2048, 2048);
    dir_tri[6] = make_tri(0, 0, 1024, 0, 0, 1024, -100, 300);
    dir_tri[7] = make_tri(-512, 0, 512, 0, 0, 0, 0, 10);
    dir_tri[8] = make_tri(CMIN, CMIN, CMAX, CMIN, 0, CMAX, 0, 0);
    dir_tri[9] = make_tri(CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, 0, 0);
    dir_tri[10] = make_tri(CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX);
    dir_tri[11] = make_tri(-1, -1, -1, -1, -1, -1, -1, -1);
    dir_tri[12] = make_tri(0, 0, 300, 0, 0, 300, 100, 0);
    dir_tri[13] = make_tri(CMAX, CMIN, CMIN, CMAX, -1, -1, CMAX, CMAX);
    foreach (dir_known[i]) dir_known[i] = 0;
    // all distances zero gives no result
    dir_known[0] = 1;
    dir_known[1] = 1;
    dir_known[11] = 1;
    // all vertices and the point on one line: the cross product is zero
    dir_known[3] = 1;
    foreach (dir_exp[i]) dir_exp[i] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(dir_tri[i], dir_known[i] ? dir_exp[i] : predict_coords(dir_tri[i]));
    end

    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (burst == 0) begin
        idle_gap();
        burst = $urandom_range(1, 40);
      end
      rt = rand_tri();
      send_item(rt, predict_coords(rt));
      burst--;
    end
    in_tvalid <= 1'b0;
    stim_done = 1;
  end

  // receiver: periodic stall pattern, plus one long hold-off to fill the pipe
  initial begin
    int cyc;
    cyc = 0;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 200 && cyc < 300) out_tready <= 1'b0;
      else if (cyc >= 1500 && cyc < 2000) out_tready <= 1'b1;
      else out_tready <= ((cyc % 7) < 4) || ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    edge_coord_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.found = out_tuser;
      got.edge_start = out_tdata[1:0];
      got.edge_weight = out_tdata[2 +: WF+1];
      got.apex_weight = out_tdata[WF+3 +: WF+1];
      if (coord_q.size() == 0) begin
        $error("result with none expected");
        errors++;
      end else begin
        want = coord_q.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d actual %0d", want.found, got.found);
          errors++;
        end
        if (got.edge_start !== want.edge_start) begin
          $error("edge_start: expected %0d actual %0d", want.edge_start, got.edge_start);
          errors++;
        end
        if (got.edge_weight !== want.edge_weight) begin
          $error("edge_weight: expected %0d actual %0d", want.edge_weight,
                 got.edge_weight);
          errors++;
        end
        if (got.apex_weight !== want.apex_weight) begin
          $error("apex_weight: expected %0d actual %0d", want.apex_weight,
                 got.apex_weight);
          errors++;
        end
      end
    end
  end

  initial begin
    int waited;
    wait (stim_done);
    waited = 0;
    while (coord_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    if (coord_q.size() != 0) errors++;
    repeat (60) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tpec_pkg.sv
rtl/core/tpec_frac.sv
rtl/core/triangle_point_edge_coordinates.sv
rtl/core/tpec_checker.sv
dv/triangle_point_edge_coordinates_tb.sv
